// File: design/mik_pkg.sv
`default_nettype none
package mik_pkg;

    // Lane and word sizes used across the pipeline.
    localparam int NUM_LANES  = 8;
    localparam int RW         = 12;
    localparam int QW         = 31;
    localparam int XYW        = 33;
    localparam int MAX_STAGES = 24;

    // CORDIC gain constant in Q2.30 and 30/pi in Q16.
    localparam logic signed [XYW-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic [19:0]           RPM_FACTOR  = 20'd625823;

    // Saturation bounds of a 24-bit signed result.
    localparam logic [QW-1:0] POS_LIMIT = 31'd8388607;
    localparam logic [QW-1:0] NEG_LIMIT = 31'd8388608;

    // Truncated atan(2^-i) in 32-bit binary turns.
    localparam logic [31:0] ATAN_TURNS [0:MAX_STAGES-1] = '{
        32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335086,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41721,     32'd20860,
        32'd10430,     32'd5215,      32'd2607,      32'd1303,
        32'd651,       32'd325,       32'd162,       32'd81
    };

    // Configuration register indexes.
    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_DEPTH  = 2'd1;
    localparam logic [1:0] REG_TRACK  = 2'd2;

    // One CORDIC cell's contents, with the command riding along.
    typedef struct packed {
        logic                  vld;
        logic [1:0]            quad;
        logic signed [XYW-1:0] x;
        logic signed [XYW-1:0] y;
        logic signed [XYW-1:0] z;
        logic signed [15:0]    vx;
        logic signed [15:0]    vy;
        logic signed [15:0]    w;
    } t_cordic;

    // One divider cell's contents: eight lanes of remainder and shifting quotient.
    typedef struct packed {
        logic                                vld;
        logic [NUM_LANES-1:0]                neg;
        logic [NUM_LANES-1:0][RW-1:0]        rem;
        logic [NUM_LANES-1:0][QW-1:0]        num;
    } t_div;

    // Apply the sign to a magnitude and clamp to the 24-bit range.
    function automatic logic [23:0] f_sat(input logic neg, input logic [QW-1:0] q);
        logic [23:0] res;
        if (!neg) begin
            res = (q > POS_LIMIT) ? 24'h7FFFFF : q[23:0];
        end else begin
            res = (q > NEG_LIMIT) ? 24'h800000 : 24'(-q[23:0]);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// File: design/mik_cordic_cell.sv
`default_nettype none
module mik_cordic_cell
    import mik_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_en,
    input  t_cordic i_c,
    output t_cordic o_c
);

    t_cordic               r_c;
    t_cordic               n_c;
    logic signed [XYW-1:0] xs;
    logic signed [XYW-1:0] ys;
    logic signed [XYW-1:0] atan_v;

    // One rotation step toward zero residual angle.
    always_comb begin
        xs     = i_c.x >>> STAGE;
        ys     = i_c.y >>> STAGE;
        atan_v = $signed({1'b0, ATAN_TURNS[STAGE]});
        n_c    = i_c;
        if (!i_c.z[XYW-1]) begin
            n_c.x = i_c.x - ys;
            n_c.y = i_c.y + xs;
            n_c.z = i_c.z - atan_v;
        end else begin
            n_c.x = i_c.x + ys;
            n_c.y = i_c.y - xs;
            n_c.z = i_c.z + atan_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c.vld <= 1'b0;
        end else if (i_en) begin
            r_c <= n_c;
        end
    end

    assign o_c = r_c;

endmodule
`default_nettype wire

// File: design/mik_div_cell.sv
`default_nettype none
module mik_div_cell
    import mik_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_en,
    input  wire [RW-1:0] i_radius,
    input  t_div         i_d,
    output t_div         o_d
);

    t_div          r_d;
    t_div          n_d;
    logic [RW:0]   trial [NUM_LANES];
    logic          ge    [NUM_LANES];

    // One restoring division step per lane: one quotient bit per cell.
    always_comb begin
        n_d = i_d;
        for (int k = 0; k < NUM_LANES; k++) begin
            trial[k] = {i_d.rem[k], i_d.num[k][QW-1]};
            ge[k]    = (trial[k] >= {1'b0, i_radius});
            n_d.rem[k] = ge[k] ? RW'(trial[k] - {1'b0, i_radius}) : trial[k][RW-1:0];
            n_d.num[k] = {i_d.num[k][QW-2:0], ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule
`default_nettype wire

// File: design/mecanum_inverse_kinematics.sv
// Pipeline from an accepted input beat to its output beat: the CORDIC cells,
// five mixing stages, 31 divider cells, one output register.
// Throughput: one beat per cycle while the output side is ready; a stalled output
// holds the whole pipeline.
// Reset: synchronous, active low; clears all valid flags and loads the register defaults.
`default_nettype none
module mecanum_inverse_kinematics
    import mik_pkg::*;
#(
    parameter int CORDIC_STAGES = 16,
    parameter int ANGLE_BITS    = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // vel_x[15:0], vel_y[31:16], yaw_rate[47:32], heading[63:48]
    input  wire [63:0]   i_s_axis_tdata,
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // wheel0_rad..wheel3_rad [95:0], then wheel0_rpm..wheel3_rpm [191:96], 24 bits each
    output logic [191:0] o_m_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    input  wire          i_cfg_we,
    input  wire [1:0]    i_cfg_addr,
    input  wire [11:0]   i_cfg_wdata
);

    localparam int NSTG = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
    localparam int DROP = (ANGLE_BITS < 16) ? (16 - ANGLE_BITS) : 0;

    logic          en;
    logic [RW-1:0] r_radius;
    logic [RW-1:0] r_depth;
    logic [RW-1:0] r_track;
    logic [RW-1:0] radius_eff;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 12'd50;
            r_depth  <= 12'd250;
            r_track  <= 12'd270;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_RADIUS: r_radius <= i_cfg_wdata;
                REG_DEPTH:  r_depth  <= i_cfg_wdata;
                REG_TRACK:  r_track  <= i_cfg_wdata;
                default:    ;
            endcase
        end
    end

    assign radius_eff = (r_radius == '0) ? 12'd1 : r_radius;

    // The pipeline advances whenever the output register can take a beat.
    logic r_out_valid;
    assign en              = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // Quadrant reduction of the heading.
    logic [15:0] h_m;
    logic [15:0] h_q;
    logic [1:0]  quad;
    logic [15:0] h_res;
    t_cordic     c_pipe [0:NSTG];

    always_comb begin
        h_m   = i_s_axis_tdata[63:48] & (16'hFFFF << DROP);
        h_q   = h_m + 16'h2000;
        quad  = h_q[15:14];
        h_res = h_m - {quad, 14'b0};
        c_pipe[0].vld  = i_s_axis_tvalid;
        c_pipe[0].quad = quad;
        c_pipe[0].x    = CORDIC_GAIN;
        c_pipe[0].y    = '0;
        c_pipe[0].z    = $signed({h_res[15], h_res, 16'b0});
        c_pipe[0].vx   = $signed(i_s_axis_tdata[15:0]);
        c_pipe[0].vy   = $signed(i_s_axis_tdata[31:16]);
        c_pipe[0].w    = $signed(i_s_axis_tdata[47:32]);
    end

    // Chain of CORDIC cells.
    for (genvar g = 0; g < NSTG; g++) begin : g_cordic
        mik_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_c    (c_pipe[g]),
            .o_c    (c_pipe[g+1])
        );
    end

    // Stage A: round to Q16 and undo the quadrant reduction.
    t_cordic            c_end;
    logic signed [32:0] x_rnd;
    logic signed [32:0] y_rnd;
    logic signed [18:0] c_raw;
    logic signed [18:0] s_raw;
    logic signed [18:0] n_a_c;
    logic signed [18:0] n_a_s;
    logic               r_a_vld;
    logic signed [18:0] r_a_c;
    logic signed [18:0] r_a_s;
    logic signed [15:0] r_a_vx;
    logic signed [15:0] r_a_vy;
    logic signed [15:0] r_a_w;

    assign c_end = c_pipe[NSTG];

    always_comb begin
        x_rnd = (c_end.x + 33'sd8192) >>> 14;
        y_rnd = (c_end.y + 33'sd8192) >>> 14;
        c_raw = x_rnd[18:0];
        s_raw = y_rnd[18:0];
        unique case (c_end.quad)
            2'd0: begin n_a_c = c_raw;  n_a_s = s_raw;  end
            2'd1: begin n_a_c = -s_raw; n_a_s = c_raw;  end
            2'd2: begin n_a_c = -c_raw; n_a_s = -s_raw; end
            default: begin n_a_c = s_raw; n_a_s = -c_raw; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= c_end.vld;
            r_a_c   <= n_a_c;
            r_a_s   <= n_a_s;
            r_a_vx  <= c_end.vx;
            r_a_vy  <= c_end.vy;
            r_a_w   <= c_end.w;
        end
    end

    // Stage B: velocity products and the yaw product.
    logic signed [19:0] c_m_s;
    logic signed [19:0] s_p_c;
    logic signed [19:0] s_m_c;
    logic [12:0]        dpt;
    logic               r_b_vld;
    logic signed [35:0] r_b_p [4];
    logic signed [31:0] r_b_yaw;

    always_comb begin
        c_m_s = 20'(r_a_c) - 20'(r_a_s);
        s_p_c = 20'(r_a_s) + 20'(r_a_c);
        s_m_c = 20'(r_a_s) - 20'(r_a_c);
        dpt   = 13'(r_depth) + 13'(r_track);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld  <= r_a_vld;
            r_b_p[0] <= 36'(c_m_s) * 36'(r_a_vx);
            r_b_p[1] <= 36'(s_p_c) * 36'(r_a_vy);
            r_b_p[2] <= 36'(s_p_c) * 36'(r_a_vx);
            r_b_p[3] <= 36'(s_m_c) * 36'(r_a_vy);
            r_b_yaw  <= 32'($signed({1'b0, dpt})) * 32'(r_a_w);
        end
    end

    // Stage C: mix into four wheel sums (Q16 mm/s).
    logic signed [34:0] ca;
    logic signed [34:0] cb;
    logic signed [34:0] yaw8;
    logic               r_c_vld;
    logic signed [34:0] r_c_sum [4];

    always_comb begin
        ca   = 35'(r_b_p[0]) + 35'(r_b_p[1]);
        cb   = 35'(r_b_p[2]) + 35'(r_b_p[3]);
        yaw8 = 35'(r_b_yaw) <<< 3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld    <= r_b_vld;
            r_c_sum[0] <= ca + yaw8;
            r_c_sum[1] <= cb - yaw8;
            r_c_sum[2] <= ca - yaw8;
            r_c_sum[3] <= cb + yaw8;
        end
    end

    // Stage D: magnitudes, rounded rad dividend, rpm partial products.
    logic [33:0]  mag     [4];
    logic [34:0]  rad_acc [4];
    logic         r_d_vld;
    logic [3:0]   r_d_neg;
    logic [26:0]  r_d_trad [4];
    logic [36:0]  r_d_lo [4];
    logic [36:0]  r_d_hi [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            mag[k]     = r_c_sum[k][34] ? 34'(-r_c_sum[k]) : 34'(r_c_sum[k]);
            rad_acc[k] = 35'(mag[k]) + (35'(radius_eff) << 7);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (en) begin
            r_d_vld <= r_c_vld;
            for (int k = 0; k < 4; k++) begin
                r_d_neg[k]  <= r_c_sum[k][34];
                r_d_trad[k] <= rad_acc[k][34:8];
                r_d_lo[k]   <= 37'(mag[k][16:0]) * 37'(RPM_FACTOR);
                r_d_hi[k]   <= 37'(mag[k][33:17]) * 37'(RPM_FACTOR);
            end
        end
    end

    // Stage E: rounded rpm dividend, then load the divider lanes.
    logic [54:0] prod [4];
    t_div        d_pipe [0:QW];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            prod[k] = 55'({r_d_hi[k], 17'b0}) + 55'(r_d_lo[k]) + (55'(radius_eff) << 23);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            d_pipe[0].vld <= 1'b0;
        end else if (en) begin
            d_pipe[0].vld <= r_d_vld;
            for (int k = 0; k < 4; k++) begin
                d_pipe[0].neg[k]     <= r_d_neg[k];
                d_pipe[0].neg[k + 4] <= r_d_neg[k];
                d_pipe[0].rem[k]     <= '0;
                d_pipe[0].rem[k + 4] <= '0;
                d_pipe[0].num[k]     <= QW'(r_d_trad[k]);
                d_pipe[0].num[k + 4] <= prod[k][54:24];
            end
        end
    end

    // Chain of divider cells, one quotient bit each.
    for (genvar g = 0; g < QW; g++) begin : g_div
        mik_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_radius(radius_eff),
            .i_d     (d_pipe[g]),
            .o_d     (d_pipe[g+1])
        );
    end

    // Output register: sign, saturate and pack the beat.
    logic [191:0] r_out_data;
    logic [191:0] n_out_data;

    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            n_out_data[24*k +: 24] = f_sat(d_pipe[QW].neg[k], d_pipe[QW].num[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d_pipe[QW].vld;
            r_out_data  <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire

// File: design/mik_checker.sv
`default_nettype none
module mik_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         o_s_axis_tready,
    input wire         o_m_axis_tvalid,
    input wire         i_m_axis_tready,
    input wire [191:0] o_m_axis_tdata
);

    // Reset empties the pipeline, so no beat is offered right after it.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output beat offered right after reset");

    // A stalled output beat must stall the input side too.
    a_stall_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input accepted while output is stalled");

    // A ready output side never blocks the input side.
    a_ready_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tready |-> o_s_axis_tready)
        else $error("input blocked while output side is ready");

    // A stalled output beat keeps its data.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled output beat changed");

endmodule

bind mecanum_inverse_kinematics mik_checker u_mik_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata)
);
`default_nettype wire

// File: tb/mecanum_inverse_kinematics_test.sv
`default_nettype none

// Scoreboard: predicts the wheel speeds of each accepted command and checks each output beat.
class wheel_speed_scoreboard;
    logic [11:0]   radius;
    logic [11:0]   depth;
    logic [11:0]   track;
    logic [191:0]  speeds_due[$];
    int            errors;

    function new();
        radius = 12'd50;
        depth  = 12'd250;
        track  = 12'd270;
        errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [11:0] val);
        if (idx == mik_pkg::REG_RADIUS) begin
            radius = val;
        end else if (idx == mik_pkg::REG_DEPTH) begin
            depth = val;
        end else if (idx == mik_pkg::REG_TRACK) begin
            track = val;
        end
    endfunction

    function longint round_div(longint n, longint d);
        longint mag;
        longint q;
        mag = (n < 0) ? -n : n;
        q = (mag + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    function logic [23:0] clamp24(longint v);
        if (v > 64'sd8388607) v = 64'sd8388607;
        if (v < -64'sd8388608) v = -64'sd8388608;
        return v[23:0];
    endfunction

    // Heading into quadrant and residual, then a 16-stage rotation CORDIC.
    function void heading_trig(logic [15:0] h, output longint cos_q16, output longint sin_q16);
        logic [31:0] ang;
        logic [31:0] resid;
        logic [1:0]  quad;
        longint      x, y, z, xs, ys, c, s;
        ang   = {h, 16'h0000};
        quad  = 2'((ang + 32'h2000_0000) >> 30);
        resid = ang - ({30'd0, quad} << 30);
        z = longint'(signed'(resid));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - longint'(mik_pkg::ATAN_TURNS[i]);
            end else begin
                x = x + ys; y = y - xs; z = z + longint'(mik_pkg::ATAN_TURNS[i]);
            end
        end
        c = (x + 8192) >>> 14;
        s = (y + 8192) >>> 14;
        case (quad)
            2'd0: begin cos_q16 = c;  sin_q16 = s;  end
            2'd1: begin cos_q16 = -s; sin_q16 = c;  end
            2'd2: begin cos_q16 = -c; sin_q16 = -s; end
            default: begin cos_q16 = s; sin_q16 = -c; end
        endcase
    endfunction

    function void note_cmd(logic [63:0] cmd);
        longint vx, vy, w, c, s, ca, cb, yaw, r;
        longint sum[4];
        logic [191:0] speeds;
        vx = longint'(signed'(cmd[15:0]));
        vy = longint'(signed'(cmd[31:16]));
        w  = longint'(signed'(cmd[47:32]));
        heading_trig(cmd[63:48], c, s);
        ca  = (c - s) * vx + (s + c) * vy;
        cb  = (c + s) * vx + (s - c) * vy;
        yaw = (longint'(depth) + longint'(track)) * w * 8;
        sum[0] = ca + yaw;
        sum[1] = cb - yaw;
        sum[2] = ca - yaw;
        sum[3] = cb + yaw;
        // A zero radius divides as one.
        r = (radius == 0) ? 1 : longint'(radius);
        for (int k = 0; k < 4; k++) begin
            speeds[24*k +: 24]     = clamp24(round_div(sum[k], r * 256));
            speeds[96 + 24*k +: 24] = clamp24(round_div(sum[k] * 625823, r * 16777216));
        end
        speeds_due.push_back(speeds);
    endfunction

    function void check_result(logic [191:0] got);
        logic [191:0] want;
        string names[8];
        names = '{"wheel0_rad", "wheel1_rad", "wheel2_rad", "wheel3_rad",
                  "wheel0_rpm", "wheel1_rpm", "wheel2_rpm", "wheel3_rpm"};
        if (speeds_due.size() == 0) begin
            $error("output beat with no command pending: %h", got);
            errors++;
            return;
        end
        want = speeds_due.pop_front();
        for (int k = 0; k < 8; k++) begin
            if (got[24*k +: 24] !== want[24*k +: 24]) begin
                $error("%s expected %0d actual %0d", names[k],
                       signed'(want[24*k +: 24]), signed'(got[24*k +: 24]));
                errors++;
            end
        end
    endfunction
endclass

module mecanum_inverse_kinematics_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic          i_clk;
    logic          i_rst_n;
    logic [63:0]   i_s_axis_tdata;
    logic          i_s_axis_tvalid;
    logic          o_s_axis_tready;
    logic [191:0]  o_m_axis_tdata;
    logic          o_m_axis_tvalid;
    logic          i_m_axis_tready;
    logic          i_cfg_we;
    logic [1:0]    i_cfg_addr;
    logic [11:0]   i_cfg_wdata;

    wheel_speed_scoreboard sb;
    int idle_pct;
    int stall_pct;

    mecanum_inverse_kinematics u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver stalls at the rate of the current phase.
    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Observe accepted beats on both sides.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) sb.note_cmd(i_s_axis_tdata);
            if (o_m_axis_tvalid && i_m_axis_tready) sb.check_result(o_m_axis_tdata);
        end
    end

    initial begin
        #2_000_000;
        $display("FAIL mecanum_inverse_kinematics");
        $finish;
    end

    task automatic send_cmd(input logic [63:0] cmd);
        while ($urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= cmd;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.speeds_due.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_speed();
        logic [15:0] corner[4];
        corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        if ($urandom_range(7) == 0) return corner[$urandom_range(3)];
        return 16'($urandom);
    endfunction

    initial begin
        logic [15:0] hd[8];
        sb = new();
        idle_pct        = 0;
        stall_pct       = 0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = mik_pkg::REG_RADIUS;
        i_cfg_wdata     = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed commands: field extremes and quadrant boundaries of the heading.
        hd = '{16'h0000, 16'h1FFF, 16'h2000, 16'h4000, 16'h6000, 16'h8000, 16'hE000, 16'hFFFF};
        send_cmd(64'h0);
        send_cmd({16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF});
        send_cmd({16'h0000, 16'h8000, 16'h8000, 16'h8000});
        send_cmd({16'h4000, 16'h8000, 16'h7FFF, 16'h8000});
        for (int i = 0; i < 8; i++) begin
            send_cmd({hd[i], 16'h1000, 16'h0000, 16'h03E8});
            send_cmd({hd[i], 16'h8000, 16'h7FFF, 16'h8000});
        end
        drain();

        // Phases cycle through register settings and idle and stall patterns.
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: ;
                1: begin write_reg(mik_pkg::REG_RADIUS, 12'd1);
                         write_reg(mik_pkg::REG_DEPTH, 12'd0);
                         write_reg(mik_pkg::REG_TRACK, 12'd0); end
                2: begin write_reg(mik_pkg::REG_RADIUS, 12'hFFF);
                         write_reg(mik_pkg::REG_DEPTH, 12'hFFF);
                         write_reg(mik_pkg::REG_TRACK, 12'hFFF); end
                // A zero radius divides as one; index three is not a register.
                3: begin write_reg(mik_pkg::REG_RADIUS, 12'd0);
                         write_reg(2'd3, 12'h5A5); end
                default: begin
                    write_reg(mik_pkg::REG_RADIUS, 12'($urandom_range(4095)));
                    write_reg(mik_pkg::REG_DEPTH, 12'($urandom));
                    write_reg(mik_pkg::REG_TRACK, 12'($urandom));
                end
            endcase
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 64; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 64; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            for (int n = 0; n < 100; n++) begin
                send_cmd({16'($urandom), rand_speed(), rand_speed(), rand_speed()});
            end
            drain();
            idle_pct  = 0;
            stall_pct = 0;
        end

        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && sb.speeds_due.size() == 0) begin
            $display("PASS mecanum_inverse_kinematics");
        end else begin
            $display("FAIL mecanum_inverse_kinematics");
        end
        $finish;
    end
endmodule

`default_nettype wire

// File: filelist.f
design/mik_pkg.sv
design/mik_cordic_cell.sv
design/mik_div_cell.sv
design/mecanum_inverse_kinematics.sv
design/mik_checker.sv
tb/mecanum_inverse_kinematics_test.sv
